[design/bcg_pkg.sv]
// shared types and constants for the beat click generator
`timescale 1ns / 1ps

package bcg_pkg;

    // configuration port geometry
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 48;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MEASURE_BEATS = 3'd0,
        REG_MEASURE_UNIT  = 3'd1,
        REG_LAST_MEASURE  = 3'd2,
        REG_START_BPM     = 3'd3,
        REG_PRACTICE_EN   = 3'd4,
        REG_BPM_STEP      = 3'd5,
        REG_PRACTICE_IVL  = 3'd6
    } cfg_reg_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV_LEN,
        ST_LEN_SET,
        ST_POS,
        ST_SINE,
        ST_PHASE,
        ST_UPDATE,
        ST_DIV_MOD,
        ST_WRAP,
        ST_DONE
    } state_t;

    // measure table size
    localparam int MAX_MEASURES = 8;

    // timing and tone constants
    localparam logic [22:0] CLICK_LEN          = 23'd882;
    localparam logic [23:0] BEAT_NUMERATOR     = 24'd10584000;
    localparam logic [31:0] INC_FIRST          = 32'd183096111;
    localparam logic [31:0] INC_OTHER          = 32'd85704563;
    localparam logic [63:0] HALF_PI_Q30        = 64'd1686629713;
    localparam logic [22:0] RESET_BEAT_LENGTH  = 23'd66150;

    // serial step counts (last step index)
    localparam logic [4:0] DIV_LAST   = 5'd22;
    localparam logic [4:0] PHASE_LAST = 5'd31;

    // register reset values
    localparam logic [47:0] RST_MEASURE_BEATS = 48'd0;
    localparam logic [15:0] RST_MEASURE_UNIT  = 16'd0;
    localparam logic [2:0]  RST_LAST_MEASURE  = 3'd0;
    localparam logic [7:0]  RST_START_BPM     = 8'd80;
    localparam logic        RST_PRACTICE_EN   = 1'b0;
    localparam logic [6:0]  RST_BPM_STEP      = 7'd0;
    localparam logic [7:0]  RST_PRACTICE_IVL  = 8'd1;

endpackage

[design/beat_click_generator_core.sv]
// beat click generator: bit-serial divider, serial phase adder and click sequencer
`timescale 1ns / 1ps
// Sequence: a word taken in idle runs the prepare, table address, sine, update and done states,
// with a bit-serial 23-step beat length divide when a beat starts, a bit-serial phase
// accumulator add inside the click and a beat wrap on the same divider when a beat ends.
// Flow: one word in flight; the input stalls from the take until the result is loaded;
// a new word is taken while the result waits, an unread result holds back the next load.
// Reset: asynchronous, active low; control and settings registers reset, tempo 80 bpm.

module beat_click_generator_core #(
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_write,
    input  logic [bcg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bcg_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            restart,
    // output channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [15:0]              sample,
    output logic [5:0]                      beat_number,
    output logic                            beat_boundary,
    output logic [2:0]                      measure_number,
    output logic [7:0]                      tempo
);

    import bcg_pkg::*;

    localparam int DW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PW = 30 + DW;

    // two truncated Q30 products
    function automatic logic [63:0] qw_mul2(input logic [63:0] t, input logic [63:0] x);
        logic [63:0] r;
        begin
            r = (t * x) >> 30;
            r = (r * x) >> 30;
            return r;
        end
    endfunction

    // quarter-wave entry: Q30 Taylor sine up to x^13, rounded to Q14
    function automatic logic [14:0] qw_entry(input int unsigned i);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        begin
            x    = (64'(i) * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
            sum  = x;
            term = qw_mul2(x, x) / 64'd6;
            sum  = sum - term;
            term = qw_mul2(term, x) / 64'd20;
            sum  = sum + term;
            term = qw_mul2(term, x) / 64'd42;
            sum  = sum - term;
            term = qw_mul2(term, x) / 64'd72;
            sum  = sum + term;
            term = qw_mul2(term, x) / 64'd110;
            sum  = sum - term;
            term = qw_mul2(term, x) / 64'd156;
            sum  = sum + term;
            return 15'((sum + 64'd32768) >> 16);
        end
    endfunction

    // quarter-wave table, built at elaboration
    logic [14:0] qw_rom [SINE_TABLE_DEPTH+1];

    for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++)
    begin : g_qw
        localparam logic [14:0] QV = qw_entry(g);
        assign qw_rom[g] = QV;
    end

    // configuration registers
    logic [47:0] beats_tab_reg;
    logic [15:0] unit_tab_reg;
    logic [2:0]  last_meas_reg;
    logic [7:0]  start_bpm_reg;
    logic        prac_en_reg;
    logic [6:0]  bpm_step_reg;
    logic [7:0]  prac_ivl_reg;

    // sequencer and tempo state
    state_t      state_reg;
    state_t      state_next;
    logic [4:0]  cnt_reg;
    logic [22:0] sc_reg;
    logic [22:0] beat_len_reg;
    logic [31:0] phase_reg;
    logic [4:0]  beat_reg;
    logic [2:0]  meas_reg;
    logic [7:0]  bpm_reg;
    logic [7:0]  pass_reg;
    logic        bound_reg;
    logic        out_valid_reg;

    // datapath registers
    logic [22:0] quo_reg;
    logic [7:0]  rem_reg;
    logic [7:0]  divisor_reg;
    logic [31:0] inc_reg;
    logic        carry_reg;
    logic [DW-1:0] idx_reg;
    logic        neg_reg;
    logic signed [15:0] smp_reg;
    logic signed [15:0] out_smp_reg;
    logic [5:0]  out_beat_reg;
    logic        out_bound_reg;
    logic [2:0]  out_meas_reg;
    logic [7:0]  out_tempo_reg;

    // fsm outputs
    logic        out_load;
    logic        in_take;

    // measure lookups
    logic [1:0]  unit_code;
    logic [5:0]  beats_raw;
    logic [5:0]  beats_cl;
    logic [2:0]  last_cl;
    logic [7:0]  loaded_bpm;
    logic [7:0]  bpm_nz;
    logic [22:0] len_dividend;

    assign unit_code = unit_tab_reg[2*meas_reg +: 2];
    assign beats_raw = beats_tab_reg[6*meas_reg +: 6];
    assign beats_cl  = (beats_raw < 6'd2) ? 6'd2 : ((beats_raw > 6'd32) ? 6'd32 : beats_raw);
    assign last_cl   = (last_meas_reg > 3'(MAX_MEASURES - 1)) ? 3'(MAX_MEASURES - 1)
                                                              : last_meas_reg;
    assign loaded_bpm = (start_bpm_reg == 8'd0) ? 8'd1 : start_bpm_reg;
    assign bpm_nz     = (bpm_reg == 8'd0) ? 8'd1 : bpm_reg;
    // N / (bpm * unit) == (N >> log2 unit) / bpm
    assign len_dividend = 23'(BEAT_NUMERATOR >> ({1'b0, unit_code} + 3'd1));

    // restoring divider step, one quotient bit a cycle
    logic [8:0] div_shift;
    logic [9:0] div_diff;
    logic       div_fits;

    assign div_shift = {rem_reg, quo_reg[22]};
    assign div_diff  = {1'b0, div_shift} - {2'b00, divisor_reg};
    assign div_fits  = !div_diff[9];

    // table address from phase
    logic [PW-1:0] pos_prod;
    logic [DW-1:0] pos_raw;
    logic [DW-1:0] pos_cl;
    logic [DW-1:0] tab_idx;
    logic [14:0]   tab_mag;
    logic signed [15:0] smp_val;
    logic          click;

    assign pos_prod = PW'(phase_reg[29:0]) * PW'(SINE_TABLE_DEPTH);
    assign pos_raw  = pos_prod[30 +: DW];
    assign pos_cl   = (pos_raw > DW'(SINE_TABLE_DEPTH - 1)) ? DW'(SINE_TABLE_DEPTH - 1)
                                                            : pos_raw;
    assign tab_idx  = phase_reg[30] ? (DW'(SINE_TABLE_DEPTH) - pos_cl) : pos_cl;
    assign tab_mag  = qw_rom[idx_reg];
    assign smp_val  = neg_reg ? -$signed({1'b0, tab_mag}) : $signed({1'b0, tab_mag});
    assign click    = (sc_reg < CLICK_LEN);

    // serial phase adder bit
    logic sum_bit;
    logic carry_next;

    assign sum_bit    = phase_reg[0] ^ inc_reg[0] ^ carry_reg;
    assign carry_next = (phase_reg[0] & inc_reg[0]) | (phase_reg[0] & carry_reg)
                      | (inc_reg[0] & carry_reg);

    // sample counter and beat end
    logic [22:0] sc_inc;
    logic        hit_end;

    assign sc_inc  = sc_reg + 23'd1;
    assign hit_end = (sc_inc >= beat_len_reg);

    // beat wrap, measure advance and practice stepping
    logic [4:0]        beat_new;
    logic [2:0]        meas_new;
    logic [7:0]        pass_after;
    logic [7:0]        ivl_cl;
    logic              step_now;
    logic signed [9:0] bpm_sum;
    logic [7:0]        bpm_stepped;

    assign beat_new   = rem_reg[4:0];
    assign meas_new   = (meas_reg < last_cl) ? (meas_reg + 3'd1) : 3'd0;
    assign pass_after = (meas_new == 3'd0) ? (pass_reg + 8'd1) : pass_reg;
    assign ivl_cl     = (prac_ivl_reg == 8'd0) ? 8'd1 : prac_ivl_reg;
    assign step_now   = (pass_after >= ivl_cl);
    assign bpm_sum    = $signed({2'b00, bpm_reg}) + 10'($signed(bpm_step_reg));
    assign bpm_stepped = (bpm_sum < 10'sd1)   ? 8'd1 :
                         (bpm_sum > 10'sd255) ? 8'd255 : bpm_sum[7:0];

    // fsm outputs
    always_comb
    begin
        in_stall = (state_reg != ST_IDLE);
        in_take  = (state_reg == ST_IDLE) && in_valid;
        out_load = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
    end

    // fsm next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                if (sc_reg == 23'd0)
                    state_next = ST_DIV_LEN;
                else
                    state_next = ST_POS;
            end
            ST_DIV_LEN:
            begin
                if (cnt_reg == DIV_LAST)
                    state_next = ST_LEN_SET;
            end
            ST_LEN_SET:
                state_next = ST_POS;
            ST_POS:
                state_next = ST_SINE;
            ST_SINE:
            begin
                if (click)
                    state_next = ST_PHASE;
                else
                    state_next = ST_UPDATE;
            end
            ST_PHASE:
            begin
                if (cnt_reg == PHASE_LAST)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (hit_end)
                    state_next = ST_DIV_MOD;
                else
                    state_next = ST_DONE;
            end
            ST_DIV_MOD:
            begin
                if (cnt_reg == DIV_LAST)
                    state_next = ST_WRAP;
            end
            ST_WRAP:
                state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beats_tab_reg <= RST_MEASURE_BEATS;
            unit_tab_reg  <= RST_MEASURE_UNIT;
            last_meas_reg <= RST_LAST_MEASURE;
            start_bpm_reg <= RST_START_BPM;
            prac_en_reg   <= RST_PRACTICE_EN;
            bpm_step_reg  <= RST_BPM_STEP;
            prac_ivl_reg  <= RST_PRACTICE_IVL;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MEASURE_BEATS: beats_tab_reg <= cfg_data[47:0];
                REG_MEASURE_UNIT:  unit_tab_reg  <= cfg_data[15:0];
                REG_LAST_MEASURE:  last_meas_reg <= cfg_data[2:0];
                REG_START_BPM:     start_bpm_reg <= cfg_data[7:0];
                REG_PRACTICE_EN:   prac_en_reg   <= cfg_data[0];
                REG_BPM_STEP:      bpm_step_reg  <= cfg_data[6:0];
                REG_PRACTICE_IVL:  prac_ivl_reg  <= cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    // sequencer and tempo state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= 5'd0;
            sc_reg        <= 23'd0;
            beat_len_reg  <= RESET_BEAT_LENGTH;
            phase_reg     <= 32'd0;
            beat_reg      <= 5'd0;
            meas_reg      <= 3'd0;
            bpm_reg       <= RST_START_BPM;
            pass_reg      <= 8'd0;
            bound_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // output word leaves on its handshake, a new one may replace it
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    bound_reg <= 1'b0;
                    cnt_reg   <= 5'd0;
                    if (in_take && restart)
                    begin
                        sc_reg    <= 23'd0;
                        phase_reg <= 32'd0;
                        beat_reg  <= 5'd0;
                        meas_reg  <= 3'd0;
                        pass_reg  <= 8'd0;
                        bpm_reg   <= loaded_bpm;
                    end
                end
                ST_DIV_LEN, ST_DIV_MOD:
                    cnt_reg <= cnt_reg + 5'd1;
                ST_LEN_SET:
                    beat_len_reg <= quo_reg;
                ST_SINE:
                    cnt_reg <= 5'd0;
                ST_PHASE:
                begin
                    cnt_reg   <= cnt_reg + 5'd1;
                    phase_reg <= {sum_bit, phase_reg[31:1]};
                end
                ST_UPDATE:
                begin
                    cnt_reg <= 5'd0;
                    if (hit_end)
                    begin
                        bound_reg <= 1'b1;
                        sc_reg    <= 23'd0;
                        phase_reg <= 32'd0;
                    end
                    else
                        sc_reg <= sc_inc;
                end
                ST_WRAP:
                begin
                    beat_reg <= beat_new;
                    if (beat_new == 5'd0)
                    begin
                        meas_reg <= meas_new;
                        if (prac_en_reg)
                        begin
                            if (step_now)
                            begin
                                bpm_reg  <= bpm_stepped;
                                pass_reg <= 8'd0;
                            end
                            else
                                pass_reg <= pass_after;
                        end
                    end
                end
                default:
                    ;
            endcase
        end
    end

    // datapath: divider, table address, phase increment, output word
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_PREP:
            begin
                quo_reg     <= len_dividend;
                rem_reg     <= 8'd0;
                divisor_reg <= bpm_nz;
            end
            ST_DIV_LEN, ST_DIV_MOD:
            begin
                rem_reg <= div_fits ? div_diff[7:0] : div_shift[7:0];
                quo_reg <= {quo_reg[21:0], div_fits};
            end
            ST_POS:
            begin
                idx_reg <= tab_idx;
                neg_reg <= phase_reg[31];
            end
            ST_SINE:
            begin
                smp_reg   <= click ? smp_val : 16'sd0;
                inc_reg   <= (beat_reg == 5'd0) ? INC_FIRST : INC_OTHER;
                carry_reg <= 1'b0;
            end
            ST_PHASE:
            begin
                inc_reg   <= {1'b0, inc_reg[31:1]};
                carry_reg <= carry_next;
            end
            ST_UPDATE:
            begin
                // beat wrap reuses the divider for (beat + 1) mod beats
                quo_reg     <= 23'(6'(beat_reg) + 6'd1);
                rem_reg     <= 8'd0;
                divisor_reg <= 8'(beats_cl);
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_smp_reg   <= smp_reg;
                    out_beat_reg  <= 6'(beat_reg) + 6'd1;
                    out_bound_reg <= bound_reg;
                    out_meas_reg  <= meas_reg;
                    out_tempo_reg <= bpm_reg;
                end
            end
            default:
                ;
        endcase
    end

    // output word
    assign out_valid      = out_valid_reg;
    assign sample         = out_smp_reg;
    assign beat_number    = out_beat_reg;
    assign beat_boundary  = out_bound_reg;
    assign measure_number = out_meas_reg;
    assign tempo          = out_tempo_reg;

endmodule

[design/bcg_checker.sv]
// port-level checks for the beat click generator, bound to the top level
`timescale 1ns / 1ps

module bcg_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic signed [15:0]              sample,
    input logic [5:0]                      beat_number,
    input logic [7:0]                      tempo
);

    // one word in flight: the input side closes right after taking a word
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after a word was taken");

    // a waiting output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(sample) && $stable(tempo)
                                      && $stable(beat_number)))
        else $error("stalled output word changed");

    // beat number stays within a measure
    a_beat_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (beat_number != 6'd0 && beat_number <= 6'd32))
        else $error("beat number out of range");

    // tempo never reaches zero
    a_tempo_nz: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (tempo != 8'd0))
        else $error("tempo of zero");

    // click stays within half scale
    a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sample >= -16'sd16384 && sample <= 16'sd16384))
        else $error("sample beyond half scale");

endmodule

bind beat_click_generator_core bcg_checker u_bcg_checker (.*);

[verif/beat_click_generator_core_test.sv]
// self-checking testbench for the beat click generator core
`timescale 1ns / 1ps

module beat_click_generator_core_test;
    import bcg_pkg::*;

    localparam int              SINE_DEPTH       = 256;
    localparam int              CLICK_TICKS      = 882;
    localparam int unsigned     TICK_DIVIDEND    = 10584000;
    localparam logic [31:0]     STEP_ACCENT      = 32'd183096111;
    localparam logic [31:0]     STEP_PLAIN       = 32'd85704563;
    localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
    localparam int              STALL_LIMIT      = 5000;
    localparam int              DRAIN_CYCLES     = 120;
    localparam int              PRINT_CAP        = 50;

    // one output word of the block
    typedef struct packed {
        logic signed [15:0] sample;
        logic [5:0]         beat;
        logic               boundary;
        logic [2:0]         measure;
        logic [7:0]         tempo;
    } click_word_t;

    // tracks the metronome state and the words still owed by the block
    class click_scoreboard;
        // register copies
        logic [47:0] beats_tbl;
        logic [15:0] unit_tbl;
        logic [2:0]  last_meas;
        logic [7:0]  start_tempo;
        logic        practice_on;
        logic [6:0]  tempo_step;
        logic [7:0]  pass_target;
        // running state
        logic [22:0] pos_in_beat;
        logic [22:0] beat_len;
        logic [31:0] phase;
        logic [4:0]  beat_idx;
        logic [2:0]  meas_idx;
        logic [7:0]  bpm;
        logic [7:0]  passes;
        int          quarter_sine[SINE_DEPTH+1];
        click_word_t pending_clicks[$];
        int          mismatches;
        int          clicks_checked;
        int          beat_ends;
        int          tempo_moves;
        int          restarts;

        function new();
            build_quarter_sine();
            beats_tbl   = 48'd0;
            unit_tbl    = 16'd0;
            last_meas   = 3'd0;
            start_tempo = 8'd80;
            practice_on = 1'b0;
            tempo_step  = 7'd0;
            pass_target = 8'd1;
            pos_in_beat = '0;
            phase       = '0;
            beat_idx    = '0;
            meas_idx    = '0;
            passes      = '0;
            bpm         = 8'(loaded_tempo());
            recompute_length();
            mismatches     = 0;
            clicks_checked = 0;
            beat_ends      = 0;
            tempo_moves    = 0;
            restarts       = 0;
        endfunction

        // truncating Q30 taylor series up to the x^13 term
        function longint unsigned taylor_sine(longint unsigned x);
            longint unsigned sum;
            longint unsigned term;
            int k;
            sum  = x;
            term = x;
            for (k = 1; k <= 6; k++)
            begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / ((2 * k) * (2 * k + 1));
                if (k % 2 == 1)
                    sum -= term;
                else
                    sum += term;
            end
            return sum;
        endfunction

        function void build_quarter_sine();
            longint unsigned angle;
            int i;
            for (i = 0; i <= SINE_DEPTH; i++)
            begin
                angle = (64'(i) * QUARTER_TURN_Q30) / SINE_DEPTH;
                quarter_sine[i] = int'((taylor_sine(angle) + 64'd32768) >> 16);
            end
        endfunction

        function int unsigned loaded_tempo();
            return (start_tempo == 8'd0) ? 1 : start_tempo;
        endfunction

        // beat count of the active measure, held to 2..32
        function int unsigned beats_in_measure();
            int unsigned b;
            b = beats_tbl[6*meas_idx +: 6];
            if (b < 2)
                b = 2;
            if (b > 32)
                b = 32;
            return b;
        endfunction

        function int unsigned unit_of_measure();
            return 2 << unit_tbl[2*meas_idx +: 2];
        endfunction

        function void recompute_length();
            beat_len = 23'(TICK_DIVIDEND / (bpm * unit_of_measure()));
        endfunction

        // quarter-wave lookup folded into the full turn
        function int tone_at(logic [31:0] ph);
            longint unsigned scaled;
            int pos;
            int v;
            scaled = (64'(ph[29:0]) * SINE_DEPTH) >> 30;
            pos = int'(scaled);
            if (pos > SINE_DEPTH - 1)
                pos = SINE_DEPTH - 1;
            v = ph[30] ? quarter_sine[SINE_DEPTH - pos] : quarter_sine[pos];
            return ph[31] ? -v : v;
        endfunction

        // advance one sample tick and form the word it produces
        function click_word_t next_click(bit restart_now);
            click_word_t w;
            int smp;
            int delta;
            int nb;
            int unsigned ivl;
            if (restart_now)
            begin
                pos_in_beat = '0;
                phase       = '0;
                beat_idx    = '0;
                meas_idx    = '0;
                passes      = '0;
                bpm         = 8'(loaded_tempo());
            end
            if (pos_in_beat == 23'd0)
                recompute_length();
            smp = 0;
            if (pos_in_beat < CLICK_TICKS)
            begin
                smp = tone_at(phase);
                phase += (beat_idx == 5'd0) ? STEP_ACCENT : STEP_PLAIN;
            end
            pos_in_beat += 23'd1;
            w.boundary = 1'b0;
            // end of beat: wrap beat, then measure, then practice stepping
            if (pos_in_beat >= beat_len)
            begin
                w.boundary  = 1'b1;
                beat_ends++;
                pos_in_beat = '0;
                phase       = '0;
                beat_idx    = 5'((beat_idx + 1) % beats_in_measure());
                if (beat_idx == 5'd0)
                begin
                    meas_idx = (meas_idx < last_meas) ? meas_idx + 3'd1 : 3'd0;
                    if (practice_on)
                    begin
                        ivl = (pass_target == 8'd0) ? 1 : pass_target;
                        if (meas_idx == 3'd0)
                            passes += 8'd1;
                        if (passes >= ivl)
                        begin
                            delta = tempo_step[6] ? int'(tempo_step) - 128 : int'(tempo_step);
                            nb = int'(bpm) + delta;
                            if (nb < 1)
                                nb = 1;
                            if (nb > 255)
                                nb = 255;
                            if (nb != int'(bpm))
                                tempo_moves++;
                            bpm    = 8'(nb);
                            passes = '0;
                        end
                    end
                end
            end
            w.sample  = 16'(smp);
            w.beat    = {1'b0, beat_idx} + 6'd1;
            w.measure = meas_idx;
            w.tempo   = bpm;
            return w;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [47:0] val);
            case (idx)
                REG_MEASURE_BEATS: beats_tbl   = val;
                REG_MEASURE_UNIT:  unit_tbl    = val[15:0];
                REG_LAST_MEASURE:  last_meas   = val[2:0];
                REG_START_BPM:     start_tempo = val[7:0];
                REG_PRACTICE_EN:   practice_on = val[0];
                REG_BPM_STEP:      tempo_step  = val[6:0];
                REG_PRACTICE_IVL:  pass_target = val[7:0];
                default: ;
            endcase
        endfunction

        // accepted input word
        function void note_word(bit restart_now);
            if (restart_now)
                restarts++;
            pending_clicks.push_back(next_click(restart_now));
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= PRINT_CAP)
                $display("[%0t] mismatch on word %0d: %s", $time, clicks_checked, what);
        endtask

        // accepted output word against the oldest one owed
        task check_word(click_word_t got);
            click_word_t want;
            if (pending_clicks.size() == 0)
            begin
                report_mismatch("output word with none outstanding");
                return;
            end
            want = pending_clicks.pop_front();
            if (got.sample !== want.sample)
                report_mismatch($sformatf("sample %0d, expected %0d", got.sample, want.sample));
            if (got.beat !== want.beat)
                report_mismatch($sformatf("beat_number %0d, expected %0d", got.beat, want.beat));
            if (got.boundary !== want.boundary)
                report_mismatch($sformatf("beat_boundary %b, expected %b",
                                          got.boundary, want.boundary));
            if (got.measure !== want.measure)
                report_mismatch($sformatf("measure_number %0d, expected %0d",
                                          got.measure, want.measure));
            if (got.tempo !== want.tempo)
                report_mismatch($sformatf("tempo %0d, expected %0d", got.tempo, want.tempo));
            clicks_checked++;
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic                   restart;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic signed [15:0]     sample;
    logic [5:0]             beat_number;
    logic                   beat_boundary;
    logic [2:0]             measure_number;
    logic [7:0]             tempo;

    int              send_idle_pct = 0;
    int              recv_stall_pct = 0;
    int              quiet_cycles = 0;
    click_word_t     seen;
    click_scoreboard sb;

    beat_click_generator_core #(
        .SINE_TABLE_DEPTH(SINE_DEPTH)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .restart        (restart),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .sample         (sample),
        .beat_number    (beat_number),
        .beat_boundary  (beat_boundary),
        .measure_number (measure_number),
        .tempo          (tempo)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
    end

    // output word checking
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen.sample   = sample;
            seen.beat     = beat_number;
            seen.boundary = beat_boundary;
            seen.measure  = measure_number;
            seen.tempo    = tempo;
            sb.check_word(seen);
        end
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("no word moved for %0d cycles", STALL_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // one sample tick; entered and left at a falling edge
    task send_word(input bit restart_now);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        restart  <= restart_now;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_word(restart_now);
        @(negedge clk);
    endtask

    task hold_until_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending_clicks.size() != 0)
            @(negedge clk);
    endtask

    // register write, leaves the write enable high for a following write
    task write_reg(input cfg_reg_t idx, input logic [47:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        sb.write_reg(idx, val);
        @(negedge clk);
    endtask

    task apply_settings(input logic [47:0] beats, input logic [15:0] units,
                        input logic [2:0] last, input logic [7:0] start,
                        input logic prac, input logic [6:0] step, input logic [7:0] ivl);
        write_reg(REG_MEASURE_BEATS, beats);
        write_reg(REG_MEASURE_UNIT, 48'(units));
        write_reg(REG_LAST_MEASURE, 48'(last));
        write_reg(REG_START_BPM, 48'(start));
        write_reg(REG_PRACTICE_EN, 48'(prac));
        write_reg(REG_BPM_STEP, 48'(step));
        write_reg(REG_PRACTICE_IVL, 48'(ivl));
        cfg_write <= 1'b0;
    endtask

    // a run of ticks with occasional restarts and full drains
    task run_ticks(input int count, input bit open_with_restart, input int restart_per_mille);
        int n;
        bit rs;
        for (n = 0; n < count; n++)
        begin
            rs = (n == 0) ? open_with_restart : ($urandom_range(999) < restart_per_mille);
            send_word(rs);
            if ($urandom_range(799) == 0)
                hold_until_drained();
        end
    endtask

    initial
    begin
        logic [47:0] beats_pick;
        logic [15:0] units_pick;
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        restart   = 1'b0;
        sb = new();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset values: opening ticks of the first beat, restarts alone and back to back
        repeat (4) send_word(1'b0);
        send_word(1'b1);
        repeat (3) send_word(1'b0);
        send_word(1'b1);
        send_word(1'b1);
        send_word(1'b0);
        hold_until_drained();

        // measure tables and last measure at full scale, start tempo of zero loads as one
        apply_settings(48'hFFFF_FFFF_FFFF, 16'hFFFF, 3'd7, 8'd0, 1'b1, 7'h40, 8'd0);
        send_word(1'b1);
        repeat (4) send_word(1'b0);
        hold_until_drained();

        // new start tempo only takes hold on restart
        apply_settings(48'd0, 16'd0, 3'd0, 8'd255, 1'b0, 7'h3F, 8'd255);
        repeat (3) send_word(1'b0);
        send_word(1'b1);
        repeat (3) send_word(1'b0);
        hold_until_drained();

        // two short measures, zero interval, upward tempo step set
        beats_pick = 48'({$urandom(), $urandom()});
        beats_pick[11:0] = {6'd2, 6'd0};
        units_pick = 16'($urandom());
        units_pick[3:0] = 4'b1111;
        apply_settings(beats_pick, units_pick, 3'd1, 8'd250, 1'b1, 7'd32, 8'd0);
        set_idling(0, 0);
        run_ticks(300, 1'b1, 0);
        hold_until_drained();

        // over-long beat count, new settings without a restart; sender gaps
        beats_pick = 48'({$urandom(), $urandom()});
        beats_pick[5:0] = 6'd40;
        units_pick = 16'($urandom());
        units_pick[1:0] = 2'd3;
        apply_settings(beats_pick, units_pick, 3'd0, 8'd255, 1'b0, 7'h60, 8'd255);
        set_idling(61, 0);
        run_ticks(220, 1'b0, 0);
        hold_until_drained();

        // all eight measures in use, mixed units and counts; receiver stalls
        beats_pick = 48'({$urandom(), $urandom()});
        beats_pick[17:0] = {6'd33, 6'd2, 6'd1};
        units_pick = 16'($urandom());
        units_pick[5:0] = {2'd1, 2'd2, 2'd3};
        apply_settings(beats_pick, units_pick, 3'd7, 8'd240, 1'b1, 7'h7F, 8'd1);
        set_idling(0, 61);
        run_ticks(220, 1'b1, 0);
        hold_until_drained();

        // downward tempo step every second pass set; both sides idle
        beats_pick = 48'({$urandom(), $urandom()});
        beats_pick[5:0] = 6'd2;
        units_pick = 16'($urandom());
        units_pick[1:0] = 2'd3;
        apply_settings(beats_pick, units_pick, 3'd0, 8'd255, 1'b1, 7'h60, 8'd2);
        set_idling(31, 31);
        run_ticks(220, 1'b1, 0);
        hold_until_drained();

        // random settings under frequent restarts
        apply_settings(48'({$urandom(), $urandom()}), 16'($urandom()), 3'($urandom()),
                       8'($urandom_range(255)), 1'($urandom()), 7'($urandom()),
                       8'($urandom_range(255)));
        run_ticks(170, 1'b1, 200);

        // drain and settle
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("checked %0d click words across %0d beat ends, %0d tempo steps, %0d restarts",
                 sb.clicks_checked, sb.beat_ends, sb.tempo_moves, sb.restarts);
        $display("idle, stall and restart mixes over register extremes; %0d mismatches",
                 sb.mismatches);
        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[sim.f]
design/bcg_pkg.sv
design/beat_click_generator_core.sv
design/bcg_checker.sv
verif/beat_click_generator_core_test.sv
